[rtl/core/ctss_pkg.sv]
// ctss_pkg: shared widths, constants and segment tables for the clock time serializer
// no dependencies; used by ctss_encode, ctss_serialize and the top level
`timescale 1ns / 1ps
`default_nettype none

package ctss_pkg;

    localparam int HOURS_W    = 4;
    localparam int MINUTES_W  = 6;
    localparam int FRAME_BITS = 32;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    // reciprocal multiply for divide by ten, exact for values below 80 in the 14-bit product
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int DIV10_PROD_W = 14;

    typedef logic [7:0] seg_byte_t;

    // seven-segment patterns for digits 0 to 9
    localparam seg_byte_t SEG_DIGIT [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33,
        8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    // leading byte, index bit 0 = hours tens, bit 1 = pm
    localparam seg_byte_t LEAD_BYTE [4] = '{8'h10, 8'h30, 8'h18, 8'h38};

    // handshake between the input stage and the serializer
    typedef struct packed {
        logic                    valid;
        logic [FRAME_BITS-1:0]   bits;
    } frame_req_t;

endpackage

`default_nettype wire

[rtl/core/ctss_encode.sv]
// ctss_encode: input register plus digit split and segment table lookup
// depends on ctss_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctss_encode
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ctss_pkg::HOURS_W-1:0]   hours,
    input  wire logic [ctss_pkg::MINUTES_W-1:0] minutes,
    input  wire logic                           is_pm,
    output ctss_pkg::frame_req_t                frame_req,
    input  wire logic                           frame_ready
);

    logic                           hold_valid_reg;
    logic [ctss_pkg::HOURS_W-1:0]   hours_reg;
    logic [ctss_pkg::MINUTES_W-1:0] minutes_reg;
    logic                           is_pm_reg;

    logic                                  h_tens;
    logic [3:0]                            h_ones;
    logic [ctss_pkg::DIV10_PROD_W-1:0]     m_prod;
    logic [2:0]                            m_tens;
    logic [ctss_pkg::MINUTES_W-1:0]        m_tens_x10;
    logic [ctss_pkg::MINUTES_W-1:0]        m_diff;
    logic [3:0]                            m_ones;

    assign in_ready = !hold_valid_reg || frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hours_reg   <= hours;
            minutes_reg <= minutes;
            is_pm_reg   <= is_pm;
        end
    end

    // hours split by one compare
    assign h_tens = (hours_reg >= 4'd10);
    assign h_ones = h_tens ? (hours_reg - 4'd10) : hours_reg;

    // minutes split by reciprocal multiply
    assign m_prod     = ctss_pkg::DIV10_PROD_W'(minutes_reg)
                        * ctss_pkg::DIV10_PROD_W'(ctss_pkg::DIV10_MUL);
    assign m_tens     = m_prod[ctss_pkg::DIV10_SHIFT +: 3];
    assign m_tens_x10 = ctss_pkg::MINUTES_W'(m_tens) * ctss_pkg::MINUTES_W'(10);
    assign m_diff     = minutes_reg - m_tens_x10;
    assign m_ones     = m_diff[3:0];

    always_comb
    begin
        frame_req.valid       = hold_valid_reg;
        frame_req.bits[7:0]   = ctss_pkg::LEAD_BYTE[{is_pm_reg, h_tens}];
        frame_req.bits[15:8]  = ctss_pkg::SEG_DIGIT[h_ones];
        frame_req.bits[23:16] = ctss_pkg::SEG_DIGIT[{1'b0, m_tens}];
        frame_req.bits[31:24] = ctss_pkg::SEG_DIGIT[m_ones];
    end

endmodule

`default_nettype wire

[rtl/core/ctss_serialize.sv]
// ctss_serialize: frame shift register, bit counter and output register
// depends on ctss_pkg
`timescale 1ns / 1ps
`default_nettype none

module ctss_serialize
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctss_pkg::frame_req_t frame_req,
    output logic                      frame_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_data_bit,
    output logic                      out_store_pulse,
    output logic                      out_last
);

    logic [ctss_pkg::FRAME_BITS-1:0] frame_reg;
    logic [ctss_pkg::FRAME_BITS-1:0] frame_next;
    logic [ctss_pkg::CNT_W-1:0]      cnt_reg;
    logic [ctss_pkg::CNT_W-1:0]      cnt_next;
    logic                            busy_reg;
    logic                            busy_next;
    logic                            valid_reg;
    logic                            valid_next;
    logic                            data_reg;
    logic                            data_next;
    logic                            store_reg;
    logic                            store_next;

    logic advance;
    logic at_strobe;
    logic done_now;
    logic load;

    assign advance     = !valid_reg || out_ready;
    assign at_strobe   = (cnt_reg == ctss_pkg::CNT_W'(ctss_pkg::FRAME_BITS));
    assign done_now    = busy_reg && advance && at_strobe;
    assign frame_ready = !busy_reg || done_now;
    assign load        = frame_req.valid && frame_ready;

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        store_next = store_reg;

        if (advance)
        begin
            valid_next = busy_reg;
            if (busy_reg)
            begin
                data_next  = at_strobe ? 1'b0 : frame_reg[0];
                store_next = at_strobe;
                frame_next = frame_reg >> 1;
                cnt_next   = cnt_reg + ctss_pkg::CNT_W'(1);
                if (at_strobe)
                begin
                    busy_next = 1'b0;
                end
            end
        end

        if (load)
        begin
            frame_next = frame_req.bits;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        data_reg  <= data_next;
        store_reg <= store_next;
    end

    assign out_valid       = valid_reg;
    assign out_data_bit    = data_reg;
    assign out_store_pulse = store_reg;
    assign out_last        = store_reg;

`ifndef ASSERT_OFF
    a_strobe_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && store_reg) |-> !data_reg)
        else $error("strobe result carries a data bit");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= ctss_pkg::CNT_W'(ctss_pkg::FRAME_BITS)))
        else $error("bit counter past frame end");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && cnt_reg == '0))
        else $error("frame load did not restart the counter");

    a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done_now && !load |=> !busy_reg)
        else $error("serializer still busy after strobe");
`endif

endmodule

`default_nettype wire

[rtl/core/clock_time_to_segment_serializer.sv]
// clock_time_to_segment_serializer: top level, time request in, serial frame out
// depends on ctss_pkg, ctss_encode and ctss_serialize
`timescale 1ns / 1ps
`default_nettype none

// channel  | signals                           | content
// ---------+-----------------------------------+--------------------------------------
// s_axis   | s_tvalid s_tready s_tdata[15:0]   | hours, minutes, is_pm per request
// m_axis   | m_tvalid m_tready m_tdata[7:0]    | data_bit, tuser = store_pulse,
//          | m_tuser m_tlast                   | tlast on the latch strobe
//
// each request yields 33 results: 32 frame bits (lead byte first, lsb first)
// and one latch strobe, one result per cycle while m_tready is high
// sustained rate is set by the single frame shift register
// the input register takes the next request while the current frame shifts,
// and it is handed over in the cycle the strobe leaves, so frames run back to back
// rst_n clears the valid flags and the bit counter; a low m_tready stalls the
// shifter, and the input side stalls once its register is also full

module clock_time_to_segment_serializer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // hours[3:0], minutes[9:4], is_pm[10], zero[15:11]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // data_bit[0], zero[7:1]
    output logic             m_tuser,   // store_pulse[0]
    output logic             m_tlast
);

    ctss_pkg::frame_req_t frame_req;
    logic                 frame_ready;
    logic                 data_bit;

    // input register and digit encoding
    ctss_encode u_encode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .hours       (s_tdata[3:0]),
        .minutes     (s_tdata[9:4]),
        .is_pm       (s_tdata[10]),
        .frame_req   (frame_req),
        .frame_ready (frame_ready)
    );

    // frame shifter with registered result
    ctss_serialize u_serialize
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_req       (frame_req),
        .frame_ready     (frame_ready),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_data_bit    (data_bit),
        .out_store_pulse (m_tuser),
        .out_last        (m_tlast)
    );

    assign m_tdata = {7'b0, data_bit};

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// testbench for clock_time_to_segment_serializer: time requests in, serial frame bits out
// depends on ctss_pkg for port widths and on the top level rtl only
`timescale 1ns / 1ps

module testbench;

    // one serial result as it leaves the block
    typedef struct packed {
        logic data_bit;
        logic store_pulse;
        logic last;
    } serial_bit_t;

    localparam int SINK_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_PRINTED      = 20;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ctss_pkg::S_TDATA_W-1:0] s_tdata = '0;   // hours[3:0], minutes[9:4], is_pm[10], zero[15:11]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ctss_pkg::M_TDATA_W-1:0] m_tdata;        // data_bit[0], zero[7:1]
    logic                           m_tuser;        // store_pulse[0]
    logic                           m_tlast;

    // bits still owed by the block, oldest first
    serial_bit_t bits_due [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int times_sent      = 0;
    int input_stalls    = 0;
    int long_holds      = 0;

    // idling controls shared by the stimulus and the sink process
    bit source_gaps_on = 1'b0;
    bit sink_stalls_on = 1'b0;
    bit sink_hold_req  = 1'b0;

    clock_time_to_segment_serializer i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // safety net against a hung handshake
    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still due", bits_due.size());
        $display("tb: failure");
        $finish;
    end

    // seven-segment pattern of one decimal digit, segment a in bit 6
    function automatic logic [7:0] digit_segments(input int digit);
        case (digit)
            0: return 8'b0111_1110;
            1: return 8'b0011_0000;
            2: return 8'b0110_1101;
            3: return 8'b0111_1001;
            4: return 8'b0011_0011;
            5: return 8'b0101_1011;
            6: return 8'b0101_1111;
            7: return 8'b0111_0000;
            8: return 8'b0111_1111;
            default: return 8'b0111_1011;
        endcase
    endfunction

    // builds the 32-bit frame for one time and queues the 32 bits plus the strobe
    function automatic void queue_time_frame(input logic [ctss_pkg::HOURS_W-1:0] hours,
                                             input logic [ctss_pkg::MINUTES_W-1:0] minutes,
                                             input logic pm);
        logic [ctss_pkg::FRAME_BITS-1:0] frame;
        logic [7:0]                      lead;
        serial_bit_t                     one_bit;
        int                              h_tens;
        h_tens = int'(hours) / 10;
        // lead byte: colons always on in bit 4, bit 5 carries the leading one, bit 3 the pm led
        case ((h_tens + (pm ? 2 : 0)) & 3)
            0: lead = 8'b0001_0000;
            1: lead = 8'b0011_0000;
            2: lead = 8'b0001_1000;
            default: lead = 8'b0011_1000;
        endcase
        // lead byte with the hours tens goes out first, each byte lsb first
        frame = {digit_segments(int'(minutes) % 10), digit_segments(int'(minutes) / 10),
                 digit_segments(int'(hours) % 10), lead};
        for (int i = 0; i < ctss_pkg::FRAME_BITS; i++)
        begin
            one_bit = '{data_bit: frame[i], store_pulse: 1'b0, last: 1'b0};
            bits_due.push_back(one_bit);
        end
        // latch strobe closes the frame with the data line low
        one_bit = '{data_bit: 1'b0, store_pulse: 1'b1, last: 1'b1};
        bits_due.push_back(one_bit);
    endfunction

    // gap length drawn from two ranges, the lower one far more often
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch: %s at result %0d, want %0h got %0h",
                     what, results_checked, want, got);
        mismatch_count++;
    endtask

    // offers one time request and waits for the handshake; valid only drops for a gap
    task automatic send_time(input logic [ctss_pkg::HOURS_W-1:0] hours,
                             input logic [ctss_pkg::MINUTES_W-1:0] minutes,
                             input logic pm);
        int gap;
        if (source_gaps_on && $urandom_range(0, 2) == 0)
        begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ctss_pkg::S_TDATA_W - ctss_pkg::HOURS_W - ctss_pkg::MINUTES_W - 1){1'b0}},
                     pm, minutes, hours};
        do
        begin
            @(posedge clk);
            if (!s_tready)
                input_stalls++;
        end
        while (!s_tready);
        queue_time_frame(hours, minutes, pm);
        times_sent++;
    endtask

    // random time, mostly within the clock's range, sometimes any bit pattern
    task automatic send_random_time();
        logic [ctss_pkg::HOURS_W-1:0]   hours;
        logic [ctss_pkg::MINUTES_W-1:0] minutes;
        hours   = ($urandom_range(0, 4) == 0) ? ctss_pkg::HOURS_W'($urandom_range(0, 15))
                                              : ctss_pkg::HOURS_W'($urandom_range(0, 12));
        minutes = ($urandom_range(0, 4) == 0) ? ctss_pkg::MINUTES_W'($urandom_range(0, 63))
                                              : ctss_pkg::MINUTES_W'($urandom_range(0, 59));
        send_time(hours, minutes, 1'($urandom_range(0, 1)));
    endtask

    // sink ready: random stalls when enabled, plus one long hold on request
    initial
    begin : sink_ready
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                stall_left    = SINK_HOLD_CYCLES;
                long_holds++;
            end
            else if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 4) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result checker, compares each accepted result with the oldest bit due
    always @(posedge clk)
    begin : check_results
        serial_bit_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bits_due.size() == 0)
                report_mismatch("unexpected result, m_tdata", 0, int'(m_tdata));
            else
            begin
                due = bits_due.pop_front();
                if (m_tdata !== {{(ctss_pkg::M_TDATA_W - 1){1'b0}}, due.data_bit})
                    report_mismatch("data_bit", int'(due.data_bit), int'(m_tdata));
                if (m_tuser !== due.store_pulse)
                    report_mismatch("store_pulse", int'(due.store_pulse), int'(m_tuser));
                if (m_tlast !== due.last)
                    report_mismatch("last", int'(due.last), int'(m_tlast));
            end
            results_checked++;
        end
    end

    // directed times, frames back to back with no idling on either side
    task automatic test_directed_times();
        logic [ctss_pkg::MINUTES_W-1:0] minutes;
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        // every hours value, minutes spread over the digit table, pm alternating
        for (int h = 0; h < 16; h++)
        begin
            minutes = ctss_pkg::MINUTES_W'((h * 11) % 64);
            send_time(ctss_pkg::HOURS_W'(h), minutes, h[0]);
        end
        // field extremes, the digits the sweep misses, hours and minutes past range
        send_time(4'd0, 6'd0, 1'b0);
        send_time(4'd12, 6'd59, 1'b1);
        send_time(4'd15, 6'd63, 1'b1);
        send_time(4'd13, 6'd60, 1'b0);
        send_time(4'd8, 6'd58, 1'b1);
        send_time(4'd9, 6'd39, 1'b0);
        send_time(4'd10, 6'd0, 1'b1);
    endtask

    // random times with gaps on the input side and stalls on the output side
    task automatic test_random_times();
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        for (int n = 0; n < 140; n++)
        begin
            // stretches without idling now and then
            if (n == 60)
            begin
                source_gaps_on = 1'b0;
                sink_stalls_on = 1'b0;
            end
            if (n == 90)
            begin
                source_gaps_on = 1'b1;
                sink_stalls_on = 1'b1;
            end
            send_random_time();
        end
    endtask

    // output held off for a long stretch while requests keep coming, input must stall
    task automatic test_output_hold();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        sink_hold_req = 1'b1;
        for (int n = 0; n < 8; n++)
            send_random_time();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_times();
        test_random_times();
        test_output_hold();

        s_tvalid <= 1'b0;
        while (bits_due.size() != 0)
            @(posedge clk);
        // any stray result after the last frame is caught by the checker here
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d time requests (every hours value, minutes past range, pm on and off)",
                 times_sent);
        $display("checked %0d serial results, %0d long output hold(s), %0d input stall cycles",
                 results_checked, long_holds, input_stalls);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
